FILE: rtl/core/bmnr_pkg.sv
// package for the bus master node registry: sizes, codes and shared structs
package bmnr_pkg;

    localparam int NODE_SLOTS = 16;
    localparam int IDX_W      = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NODE_SLOTS + 1);
    localparam int MAC_BYTES  = 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_VER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HELLO_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PONG_CODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE    = 3'd4;

    // result status codes
    localparam logic [1:0] ST_IGNORED = 2'd0;
    localparam logic [1:0] ST_REFRESH = 2'd1;
    localparam logic [1:0] ST_INSERT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // request handed from the top level to the sequencer
    typedef struct packed {
        logic        start;
        logic        upsert;
        logic        with_mac;
        logic [15:0] key;
        logic [47:0] mac;
        logic [31:0] now;
    } t_seq_cmd;

    // finished result from the sequencer
    typedef struct packed {
        logic       done;
        logic [1:0] status;
        t_idx       where;
    } t_seq_res;

    // table write port
    typedef struct packed {
        logic        en;
        logic        insert;
        t_idx        idx;
        logic [15:0] node_id;
        logic        with_mac;
        logic [47:0] mac;
        logic [31:0] now;
    } t_tbl_wr;

    // table read port, one slot at a time plus the fill count
    typedef struct packed {
        logic        valid;
        logic [15:0] node_id;
        t_cnt        count;
    } t_tbl_rd;

endpackage

FILE: rtl/core/bus_master_node_registry.sv
// top level of the bus master node registry: filter, config, sequencer, table, output register
//
//  channel   direction  handshake                  payload
//  in        request    i_in_valid / o_in_stall    msg_version .. time_ms
//  out       result     o_out_valid / i_out_stall  status .. nodes_known
//  cfg       write      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a request that reaches the table passes a start register, a scan of the slots
// one at a time through the single id comparator, and the done state; a
// filtered request goes from the start register straight to the done state.
// a hit ends the scan early.
// reset (synchronous, active low) clears the valid bits, count and config
// registers at once; no clearing pass. o_in_stall is high while a request is
// in work; a result waits in the output register while i_out_stall is high,
// and the next request is taken meanwhile, held in its done state until then.
module bus_master_node_registry (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_msg_version,
    input  logic [7:0]                         i_msg_type,
    input  logic [15:0]                        i_msg_dest,
    input  logic [15:0]                        i_msg_source,
    input  logic [7:0]                         i_payload_length,
    input  logic [47:0]                        i_payload_mac,
    input  logic [31:0]                        i_time_ms,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic                               o_send_ack,
    output logic [7:0]                         o_ack_type,
    output logic [15:0]                        o_ack_dest,
    output logic [15:0]                        o_ack_source,
    output logic [3:0]                         o_slot_index,
    output logic [4:0]                         o_nodes_known,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bmnr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmnr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // configuration registers
    logic [15:0] r_master_addr;
    logic [7:0]  r_proto_ver;
    logic [7:0]  r_hello_code;
    logic [7:0]  r_pong_code;
    logic [7:0]  r_ack_code;

    // control
    logic r_busy;
    logic r_start;
    logic r_out_valid;

    // captured request
    logic        r_upsert;
    logic        r_hello;
    logic        r_with_mac;
    logic [15:0] r_src;
    logic [47:0] r_mac;
    logic [31:0] r_now;

    // output payload
    logic [1:0]  r_status;
    logic        r_send_ack;
    logic [7:0]  r_ack_type;
    logic [15:0] r_ack_dest;
    logic [15:0] r_ack_source;
    logic [3:0]  r_slot_index;
    logic [4:0]  r_nodes_known;

    logic in_accept;
    logic out_load;
    logic msg_for_us;
    logic is_hello;
    logic is_pong;

    bmnr_pkg::t_seq_cmd seq_cmd;
    bmnr_pkg::t_seq_res seq_res;
    bmnr_pkg::t_tbl_wr  tbl_wr;
    bmnr_pkg::t_tbl_rd  tbl_rd;
    bmnr_pkg::t_idx     rd_idx;

    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !r_busy;

    // header filter; hello wins when hello and pong codes are equal
    assign msg_for_us = (i_msg_version == r_proto_ver) && (i_msg_dest == r_master_addr);
    assign is_hello   = msg_for_us && (i_msg_type == r_hello_code);
    assign is_pong    = msg_for_us && (i_msg_type == r_pong_code);

    // result moves to the output register once it is free or being taken
    assign out_load = seq_res.done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_addr <= '0;
            r_proto_ver   <= '0;
            r_hello_code  <= '0;
            r_pong_code   <= '0;
            r_ack_code    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bmnr_pkg::CFG_MASTER_ADDR: r_master_addr <= i_cfg_data;
                bmnr_pkg::CFG_PROTO_VER:   r_proto_ver   <= i_cfg_data[7:0];
                bmnr_pkg::CFG_HELLO_CODE:  r_hello_code  <= i_cfg_data[7:0];
                bmnr_pkg::CFG_PONG_CODE:   r_pong_code   <= i_cfg_data[7:0];
                bmnr_pkg::CFG_ACK_CODE:    r_ack_code    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= in_accept;
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (out_load) begin
                r_busy <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_upsert   <= is_hello || is_pong;
            r_hello    <= is_hello;
            r_with_mac <= is_hello &&
                          (i_payload_length == 8'(bmnr_pkg::MAC_BYTES));
            r_src      <= i_msg_source;
            r_mac      <= i_payload_mac;
            r_now      <= i_time_ms;
        end
    end

    // result capture; the ack fields are zero unless a hello was processed
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status      <= seq_res.status;
            r_send_ack    <= r_hello;
            r_ack_type    <= r_hello ? r_ack_code : 8'd0;
            r_ack_dest    <= r_hello ? r_src : 16'd0;
            r_ack_source  <= r_hello ? r_master_addr : 16'd0;
            r_slot_index  <= 4'(seq_res.where);
            r_nodes_known <= 5'(tbl_rd.count);
        end
    end

    assign seq_cmd.start    = r_start;
    assign seq_cmd.upsert   = r_upsert;
    assign seq_cmd.with_mac = r_with_mac;
    assign seq_cmd.key      = r_src;
    assign seq_cmd.mac      = r_mac;
    assign seq_cmd.now      = r_now;

    bmnr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (seq_cmd),
        .i_done_ack (out_load),
        .i_rd       (tbl_rd),
        .o_rd_idx   (rd_idx),
        .o_wr       (tbl_wr),
        .o_res      (seq_res)
    );

    bmnr_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .i_wr     (tbl_wr),
        .o_rd     (tbl_rd)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_send_ack    = r_send_ack;
    assign o_ack_type    = r_ack_type;
    assign o_ack_dest    = r_ack_dest;
    assign o_ack_source  = r_ack_source;
    assign o_slot_index  = r_slot_index;
    assign o_nodes_known = r_nodes_known;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_res.done |-> r_busy)
        else $error("result without a request in work");

    a_start_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_start && r_busy))
        else $error("accepted request did not start the sequencer");

    a_ack_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_send_ack) |->
            (r_ack_type == 8'd0 && r_ack_dest == 16'd0 && r_ack_source == 16'd0))
        else $error("ack fields set without an ack");

endmodule

FILE: rtl/core/bmnr_table.sv
// slot table of the node registry: valid bits, node ids, macs, timestamps, count
module bmnr_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmnr_pkg::t_idx    i_rd_idx,
    input  bmnr_pkg::t_tbl_wr i_wr,
    output bmnr_pkg::t_tbl_rd o_rd
);

    logic [bmnr_pkg::NODE_SLOTS-1:0] r_valid;
    logic [15:0]                     r_node_id   [bmnr_pkg::NODE_SLOTS];
    logic                            r_has_mac   [bmnr_pkg::NODE_SLOTS];
    logic [47:0]                     r_mac       [bmnr_pkg::NODE_SLOTS];
    logic [31:0]                     r_last_seen [bmnr_pkg::NODE_SLOTS];
    bmnr_pkg::t_cnt                  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_wr.en && i_wr.insert) begin
            r_valid[i_wr.idx] <= 1'b1;
            if (r_count < bmnr_pkg::CNT_W'(bmnr_pkg::NODE_SLOTS)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // payload of the slots; read out ungated, beside the slot's valid bit
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_last_seen[i_wr.idx] <= i_wr.now;
            if (i_wr.insert) begin
                r_node_id[i_wr.idx] <= i_wr.node_id;
                r_has_mac[i_wr.idx] <= i_wr.with_mac;
                r_mac[i_wr.idx]     <= i_wr.with_mac ? i_wr.mac : 48'd0;
            end else if (i_wr.with_mac) begin
                r_has_mac[i_wr.idx] <= 1'b1;
                r_mac[i_wr.idx]     <= i_wr.mac;
            end
        end
    end

    assign o_rd.valid   = r_valid[i_rd_idx];
    assign o_rd.node_id = r_node_id[i_rd_idx];
    assign o_rd.count   = r_count;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bmnr_pkg::CNT_W'(bmnr_pkg::NODE_SLOTS))
        else $error("slot count above table size");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == bmnr_pkg::CNT_W'($countones(r_valid)))
        else $error("slot count differs from valid bits");

    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.en && i_wr.insert) |-> !r_valid[i_wr.idx])
        else $error("insert into occupied slot");

    a_refresh_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.en && !i_wr.insert) |->
            (r_valid[i_wr.idx] && r_node_id[i_wr.idx] == i_wr.node_id))
        else $error("refresh of a slot that does not hold the node");

endmodule

FILE: rtl/core/bmnr_seq.sv
// scan sequencer: walks the slots one per cycle through a shared id comparator
module bmnr_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bmnr_pkg::t_seq_cmd i_cmd,
    input  logic               i_done_ack,
    input  bmnr_pkg::t_tbl_rd  i_rd,
    output bmnr_pkg::t_idx     o_rd_idx,
    output bmnr_pkg::t_tbl_wr  o_wr,
    output bmnr_pkg::t_seq_res o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam bmnr_pkg::t_idx LAST_IDX = bmnr_pkg::IDX_W'(bmnr_pkg::NODE_SLOTS - 1);

    logic [1:0]     r_state,      n_state;
    bmnr_pkg::t_idx r_idx,        n_idx;
    logic           r_free_found, n_free_found;
    bmnr_pkg::t_idx r_free_idx,   n_free_idx;
    logic [1:0]     r_status,     n_status;
    bmnr_pkg::t_idx r_where,      n_where;

    logic hit;
    logic free_here;

    // the one comparator, reused for every slot
    assign hit       = i_rd.valid && (i_rd.node_id == i_cmd.key);
    assign free_here = !i_rd.valid && !r_free_found;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_status     = r_status;
        n_where      = r_where;
        o_wr          = '0;
        o_wr.node_id  = i_cmd.key;
        o_wr.with_mac = i_cmd.with_mac;
        o_wr.mac      = i_cmd.mac;
        o_wr.now      = i_cmd.now;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    if (i_cmd.upsert) begin
                        n_state      = S_SCAN;
                        n_idx        = '0;
                        n_free_found = 1'b0;
                        n_free_idx   = '0;
                    end else begin
                        n_state  = S_DONE;
                        n_status = bmnr_pkg::ST_IGNORED;
                        n_where  = '0;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    o_wr.en     = 1'b1;
                    o_wr.insert = 1'b0;
                    o_wr.idx    = r_idx;
                    n_status    = bmnr_pkg::ST_REFRESH;
                    n_where     = r_idx;
                    n_state     = S_DONE;
                end else begin
                    if (free_here) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_DONE;
                        if (r_free_found || free_here) begin
                            o_wr.en     = 1'b1;
                            o_wr.insert = 1'b1;
                            o_wr.idx    = free_here ? r_idx : r_free_idx;
                            n_status    = bmnr_pkg::ST_INSERT;
                            n_where     = free_here ? r_idx : r_free_idx;
                        end else begin
                            n_status = bmnr_pkg::ST_FULL;
                            n_where  = '0;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_done_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_free_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_free_found <= n_free_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx <= n_free_idx;
        r_status   <= n_status;
        r_where    <= n_where;
    end

    assign o_rd_idx     = r_idx;
    assign o_res.done   = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.where  = r_where;

    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> (r_state == S_SCAN))
        else $error("table write outside the scan");

    a_scan_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && (hit || r_idx == LAST_IDX)) |=> (r_state == S_DONE))
        else $error("scan did not finish on hit or last slot");

    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (r_status == bmnr_pkg::ST_FULL
            || r_status == bmnr_pkg::ST_IGNORED)) |-> (r_where == '0))
        else $error("slot index set without an update");

endmodule
